### sv/slc_pkg.sv
// Shared types, command codes and status codes for the session lifecycle sequencer.
package slc_pkg;

    // Width of the generation and sequence counters (8 to 64).
    localparam int unsigned CW = 64;

    typedef logic [CW-1:0] cnt_t;

    localparam cnt_t CNT_MAX = {CW{1'b1}};

    // Command codes carried on func
    localparam logic [2:0] FN_OPEN    = 3'd0;
    localparam logic [2:0] FN_ATTACH  = 3'd1;
    localparam logic [2:0] FN_REPLACE = 3'd2;
    localparam logic [2:0] FN_DETACH  = 3'd3;
    localparam logic [2:0] FN_RESET   = 3'd4;
    localparam logic [2:0] FN_CLOSE   = 3'd5;
    localparam logic [2:0] FN_SUBMIT  = 3'd6;
    localparam logic [2:0] FN_QUERY   = 3'd7;

    // Device state codes as reported on dev_state
    localparam logic [2:0] DS_CLOSED    = 3'd0;
    localparam logic [2:0] DS_OPEN_UNATT = 3'd1;
    localparam logic [2:0] DS_OPEN_ATT  = 3'd2;
    localparam logic [2:0] DS_CLOSING   = 3'd3;
    localparam logic [2:0] DS_DEAD      = 3'd4;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_INVALID  = 4'd1,
        ST_SHUTDOWN = 4'd2,
        ST_BUSY     = 4'd3,
        ST_OVERFLOW = 4'd4,
        ST_REFUSED  = 4'd5,
        ST_NOTCONN  = 4'd6,
        ST_STALE    = 4'd7,
        ST_ALREADY  = 4'd8,
        ST_RANGE    = 4'd9
    } status_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] claimed_gen;
        logic [63:0] sequence_req;
        logic        partner_refused;
    } slc_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  dev_state;
        logic [63:0] generation;
        logic [63:0] last_accepted_sequence;
        logic [63:0] upcoming_seq;
        logic        open_flag;
        logic        attached_flag;
        logic        result_valid_flag;
        logic        exhausted_flag;
        logic        dead_flag;
    } slc_result_t;

endpackage

### sv/slc_core.sv
// Lifecycle state, counters and result register; evaluates one command per advance.
module slc_core
    import slc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  slc_cmd_t    cmd,
    output slc_result_t result
);

    typedef enum logic [2:0] {
        LS_CLOSED    = DS_CLOSED,
        LS_OPEN_UNATT = DS_OPEN_UNATT,
        LS_OPEN_ATT  = DS_OPEN_ATT,
        LS_CLOSING   = DS_CLOSING,
        LS_DEAD      = DS_DEAD
    } lc_state_t;

    lc_state_t   state_reg, state_next;
    cnt_t        gen_reg, gen_next;
    cnt_t        last_reg, last_next;
    logic        present_reg, present_next;
    logic        spent_reg, spent_next;
    slc_result_t result_reg, result_next;

    logic        gen_max;
    logic        last_max;
    logic        is_open;
    logic [63:0] gen_wide;
    logic [63:0] last_wide;
    logic [63:0] last_inc;
    status_t     status;
    lc_state_t   target;

    assign gen_max   = (gen_reg == CNT_MAX);
    assign last_max  = (last_reg == CNT_MAX);
    assign is_open   = (state_reg == LS_OPEN_UNATT) || (state_reg == LS_OPEN_ATT);
    assign gen_wide  = 64'(gen_reg);
    assign last_wide = 64'(last_reg);
    assign last_inc  = last_wide + 64'd1;

    always_comb begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        last_next    = last_reg;
        present_next = present_reg;
        spent_next   = spent_reg;
        status       = ST_OK;
        target       = (cmd.func == FN_DETACH) ? LS_OPEN_UNATT : LS_OPEN_ATT;

        case (cmd.func)
            FN_OPEN: begin
                if (state_reg == LS_DEAD) begin
                    status = ST_SHUTDOWN;
                end else if (state_reg != LS_CLOSED) begin
                    status = ST_BUSY;
                end else begin
                    last_next    = '0;
                    present_next = 1'b0;
                    spent_next   = 1'b0;
                    if (gen_max) begin
                        state_next = LS_DEAD;
                        status     = ST_OVERFLOW;
                    end else begin
                        gen_next   = gen_reg + cnt_t'(1);
                        state_next = LS_OPEN_UNATT;
                    end
                end
            end
            FN_ATTACH, FN_REPLACE, FN_DETACH: begin
                if (state_reg == LS_DEAD) begin
                    status = ST_SHUTDOWN;
                end else if ((cmd.func == FN_ATTACH) ? (state_reg != LS_OPEN_UNATT)
                                                     : (state_reg != LS_OPEN_ATT)) begin
                    status = ST_INVALID;
                end else if (gen_max) begin
                    // overflow check outranks a refusal
                    last_next    = '0;
                    present_next = 1'b0;
                    spent_next   = 1'b0;
                    state_next   = LS_DEAD;
                    status       = ST_OVERFLOW;
                end else if (cmd.partner_refused) begin
                    status = ST_REFUSED;
                end else begin
                    last_next    = '0;
                    present_next = 1'b0;
                    spent_next   = 1'b0;
                    gen_next     = gen_reg + cnt_t'(1);
                    state_next   = target;
                end
            end
            FN_RESET, FN_CLOSE: begin
                if (!is_open) begin
                    status = (state_reg == LS_DEAD) ? ST_SHUTDOWN : ST_INVALID;
                end else begin
                    last_next    = '0;
                    present_next = 1'b0;
                    spent_next   = 1'b0;
                    if (gen_max) begin
                        state_next = LS_DEAD;
                        status     = ST_OVERFLOW;
                    end else begin
                        gen_next = gen_reg + cnt_t'(1);
                        // close moves straight to closed; the closing state is never entered
                        if (cmd.func == FN_CLOSE) begin
                            state_next = LS_CLOSED;
                        end
                    end
                end
            end
            FN_SUBMIT: begin
                if ((state_reg == LS_DEAD) || (state_reg == LS_CLOSING) ||
                    (state_reg == LS_CLOSED)) begin
                    status = ST_SHUTDOWN;
                end else if (state_reg != LS_OPEN_ATT) begin
                    status = ST_NOTCONN;
                end else if (cmd.claimed_gen != gen_wide) begin
                    status = ST_STALE;
                end else if (spent_reg || last_max) begin
                    status = ST_OVERFLOW;
                end else if (cmd.sequence_req <= last_wide) begin
                    status = ST_ALREADY;
                end else if (cmd.sequence_req != last_inc) begin
                    status = ST_RANGE;
                end else begin
                    last_next    = cmd.sequence_req[CW-1:0];
                    spent_next   = (cmd.sequence_req[CW-1:0] == CNT_MAX);
                    present_next = 1'b1;
                end
            end
            FN_QUERY: begin
                status = ST_OK;
            end
            default: begin
                status = ST_OK;
            end
        endcase

        result_next.status                 = status;
        result_next.dev_state              = state_next;
        result_next.generation             = 64'(gen_next);
        result_next.last_accepted_sequence = 64'(last_next);
        result_next.upcoming_seq           = (!spent_next && (last_next != CNT_MAX))
                                             ? 64'(last_next) + 64'd1 : 64'd0;
        result_next.open_flag              = (state_next == LS_OPEN_UNATT) ||
                                             (state_next == LS_OPEN_ATT);
        result_next.attached_flag          = (state_next == LS_OPEN_ATT);
        result_next.result_valid_flag      = present_next;
        result_next.exhausted_flag         = spent_next;
        result_next.dead_flag              = (state_next == LS_DEAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LS_CLOSED;
            gen_reg     <= '0;
            last_reg    <= '0;
            present_reg <= 1'b0;
            spent_reg   <= 1'b0;
        end else if (advance) begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            last_reg    <= last_next;
            present_reg <= present_next;
            spent_reg   <= spent_next;
        end
    end

    // Result payload only; qualified by the valid flag in the top level.
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### sv/session_lifecycle_sequencer.sv
// Top level of the session lifecycle sequencer: input register, handshake and result port.
//
// Usage:
//   The s_ channel carries one lifecycle command per transaction (func,
//   claimed_gen, sequence_req, partner_refused). The m_ channel
//   returns exactly one result transaction per command: a status plus a
//   snapshot of device state, generation, sequence counters and flags as
//   they stand after that command.
//   After s_ acceptance the command waits in the input register, is
//   evaluated from it once the result slot is free or draining and lands in
//   the result register, where m_valid rises. Throughput is one command per
//   cycle while m_ready stays high; the input and result registers form two
//   stages, so a new command is taken while a result is still waiting on m_ready.
//   A stalled receiver holds the result register; the input register then
//   holds one more command and s_ready drops until m_ready returns.
//   Reset (aresetn low, synchronous) drops both valids, sets the device to
//   closed and clears generation, last sequence and session flags.
//   Once the generation counter would pass its maximum the device goes dead
//   for good; only a query still reports ok until the next reset.
module session_lifecycle_sequencer
    import slc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [63:0] s_claimed_gen,
    input  logic [63:0] s_sequence_req,
    input  logic        s_partner_refused,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [2:0]  m_dev_state,
    output logic [63:0] m_generation,
    output logic [63:0] m_last_accepted_sequence,
    output logic [63:0] m_upcoming_seq,
    output logic        m_open_flag,
    output logic        m_attached_flag,
    output logic        m_result_valid_flag,
    output logic        m_exhausted_flag,
    output logic        m_dead_flag
);

    slc_cmd_t    cmd_reg;
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        s_accept;
    slc_result_t result;

    // Command moves into evaluation when the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload only; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg.func            <= s_func;
            cmd_reg.claimed_gen     <= s_claimed_gen;
            cmd_reg.sequence_req    <= s_sequence_req;
            cmd_reg.partner_refused <= s_partner_refused;
        end
    end

    slc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cmd     (cmd_reg),
        .result  (result)
    );

    assign m_valid                  = out_valid_reg;
    assign m_status                 = result.status;
    assign m_dev_state              = result.dev_state;
    assign m_generation             = result.generation;
    assign m_last_accepted_sequence = result.last_accepted_sequence;
    assign m_upcoming_seq           = result.upcoming_seq;
    assign m_open_flag              = result.open_flag;
    assign m_attached_flag          = result.attached_flag;
    assign m_result_valid_flag      = result.result_valid_flag;
    assign m_exhausted_flag         = result.exhausted_flag;
    assign m_dead_flag              = result.dead_flag;

    // An accepted command always lands in the input register.
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted transaction not held in input register");

    // A pending command with a free result slot must produce a result.
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("evaluated command produced no result");

    // Attached implies open; dead excludes open.
    a_flag_consistency: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_attached_flag || m_open_flag) && !(m_dead_flag && m_open_flag)))
        else $error("inconsistent state flags");

    // Exhausted sequence space reports no next sequence.
    a_exhausted_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_exhausted_flag) |-> (m_upcoming_seq == 64'd0))
        else $error("next sequence nonzero while exhausted");

endmodule
